/* design/pcd_pkg.sv */
// ============================================================================
// pcd_pkg: shared types and constants of the control-stream deframer
// Header geometry, configuration bundle, queue entry format and the
// standard control message size table.
// ============================================================================
package pcd_pkg;

    localparam int HEADER_BYTES   = 12;
    localparam int IDX_W          = $clog2(HEADER_BYTES);
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [31:0] MAGIC_RESET   = 32'h1A2B_3C4D;
    localparam logic [15:0] MAXLEN_RESET  = 16'd220;
    localparam logic [15:0] CTLTYPE_RESET = 16'd1;

    typedef enum logic [1:0] {
        CFG_MAGIC_WORD   = 2'd0,
        CFG_MAX_LENGTH   = 2'd1,
        CFG_CONTROL_TYPE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] max_length;
        logic [15:0] control_type_value;
    } t_cfg;

    typedef logic [HEADER_BYTES-1:0][7:0] t_hdr_bytes;

    // One queue entry: a whole accepted header, or one body word.
    // Body words travel in the last byte lane.
    typedef struct packed {
        logic        is_hdr;
        logic        last;
        logic [15:0] drop;
        logic        resv;
        t_hdr_bytes  bytes;
    } t_q_entry;

    function automatic logic [15:0] std_size(input logic [15:0] kind);
        logic [15:0] size;
        size = 16'd0;
        if (kind[15:4] == 12'd0) begin
            unique case (kind[3:0])
                4'd0:  size = 16'd0;
                4'd1:  size = 16'd156;
                4'd2:  size = 16'd156;
                4'd3:  size = 16'd16;
                4'd4:  size = 16'd16;
                4'd5:  size = 16'd16;
                4'd6:  size = 16'd20;
                4'd7:  size = 16'd168;
                4'd8:  size = 16'd32;
                4'd9:  size = 16'd220;
                4'd10: size = 16'd24;
                4'd11: size = 16'd28;
                4'd12: size = 16'd16;
                4'd13: size = 16'd148;
                4'd14: size = 16'd40;
                4'd15: size = 16'd24;
                default: size = 16'd0;
            endcase
        end
        return size;
    endfunction

endpackage

/* design/pptp_control_deframer_unit.sv */
// ============================================================================
// pptp_control_deframer_unit: control-stream message deframer
// Finds message headers in a byte stream, checks them and emits whole
// messages with first/last marks and a count of skipped words.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_rx_byte
//  out     | from block| o_out_valid/ i_out_stall| o_out_byte, o_first_of_packet,
//          |           |                         | o_last_of_packet,
//          |           |                         | o_dropped_before,
//          |           |                         | o_reserved_nonzero
//  cfg     | to block  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Sustained rate is one word per cycle on both sides unless a stall holds it.
// An accepted header is emitted as twelve words by the emitter while body
// words keep flowing into the entry queue; the queue drains again while the
// next header fills. A body word goes through the queue and output register.
// Reset (synchronous, active low) clears window fill, body state, drop count,
// queue pointers and the output valid; config returns to its reset values.
// o_in_stall rises only when the entry queue is full; i_out_stall holds the
// output register and backs up into the queue.
module pptp_control_deframer_unit #(
    parameter int QUEUE_DEPTH = pcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // output stream
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_first_of_packet,
    output logic        o_last_of_packet,
    output logic [15:0] o_dropped_before,
    output logic        o_reserved_nonzero
);
    import pcd_pkg::*;

    t_cfg     r_cfg;
    logic     in_accept;
    logic     q_push;
    t_q_entry q_wr_entry;
    logic     q_full;
    logic     q_valid;
    t_q_entry q_rd_entry;
    logic     q_pop;

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word         <= MAGIC_RESET;
            r_cfg.max_length         <= MAXLEN_RESET;
            r_cfg.control_type_value <= CTLTYPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC_WORD:   r_cfg.magic_word         <= i_cfg_data;
                CFG_MAX_LENGTH:   r_cfg.max_length         <= i_cfg_data[15:0];
                CFG_CONTROL_TYPE: r_cfg.control_type_value <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Hold the input side only when the queue has no free entry.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // Front: window, header check, body count.
    pcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (q_push),
        .o_entry   (q_wr_entry)
    );

    // Decouple classification from emission.
    pcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_rd_entry)
    );

    // Back: expand headers and advance body words to the output register.
    pcd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_entry          (q_rd_entry),
        .o_q_pop            (q_pop),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_byte         (o_out_byte),
        .o_first_of_packet  (o_first_of_packet),
        .o_last_of_packet   (o_last_of_packet),
        .o_dropped_before   (o_dropped_before),
        .o_reserved_nonzero (o_reserved_nonzero)
    );

endmodule

/* design/pcd_front.sv */
// ============================================================================
// pcd_front: header window and message classifier
// Shifts stream words into the header window, checks complete headers and
// pushes accepted headers and body words into the queue.
// ============================================================================
module pcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcd_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output pcd_pkg::t_q_entry o_entry
);
    import pcd_pkg::*;

    t_hdr_bytes       r_win;
    logic [IDX_W-1:0] r_fill;
    logic             r_in_body;
    logic [15:0]      r_remaining;
    logic [15:0]      r_drop;

    t_hdr_bytes  n_win;
    logic [15:0] len;
    logic [15:0] msg_type;
    logic [31:0] magic;
    logic [15:0] kind;
    logic        resv;
    logic        hdr_ok;
    logic        hdr_full;

    always_comb begin
        for (int k = 0; k < HEADER_BYTES - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[HEADER_BYTES-1] = i_rx_byte;
        len      = {n_win[0], n_win[1]};
        msg_type = {n_win[2], n_win[3]};
        magic    = {n_win[4], n_win[5], n_win[6], n_win[7]};
        kind     = {n_win[8], n_win[9]};
        resv     = |{n_win[10], n_win[11]};
        hdr_ok   = (magic == i_cfg.magic_word)
                && (len >= 16'(HEADER_BYTES))
                && (len <= i_cfg.max_length)
                && !((msg_type == i_cfg.control_type_value) && (len != std_size(kind)));
        hdr_full = (r_fill == IDX_W'(HEADER_BYTES - 1));
    end

    always_comb begin
        o_push       = i_accept && (r_in_body || (hdr_full && hdr_ok));
        o_entry.is_hdr = !r_in_body;
        o_entry.last   = r_in_body ? (r_remaining == 16'd1) : (len == 16'(HEADER_BYTES));
        o_entry.drop   = r_drop;
        o_entry.resv   = resv;
        o_entry.bytes  = n_win;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_in_body) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_in_body   <= 1'b0;
            r_remaining <= '0;
            r_drop      <= '0;
        end else if (i_accept) begin
            if (r_in_body) begin
                r_remaining <= r_remaining - 16'd1;
                if (r_remaining == 16'd1) begin
                    r_in_body <= 1'b0;
                end
            end else if (!hdr_full) begin
                r_fill <= r_fill + IDX_W'(1);
            end else if (hdr_ok) begin
                r_fill      <= '0;
                r_drop      <= '0;
                r_remaining <= len - 16'(HEADER_BYTES);
                r_in_body   <= (len != 16'(HEADER_BYTES));
            end else if (r_drop != 16'hFFFF) begin
                r_drop <= r_drop + 16'd1;
            end
        end
    end

    a_body_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_remaining != 16'd0))
        else $error("body mode with no words left");

endmodule

/* design/pcd_queue.sv */
// ============================================================================
// pcd_queue: entry queue between classifier and emitter
// Register-array FIFO; one push and one pop per cycle.
// ============================================================================
module pcd_queue #(
    parameter int DEPTH = pcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcd_pkg::t_q_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output pcd_pkg::t_q_entry o_entry
);
    import pcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* design/pcd_back.sv */
// ============================================================================
// pcd_back: message emitter
// Expands header entries into twelve words and passes body words, through
// a registered output stage.
// ============================================================================
module pcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  pcd_pkg::t_q_entry i_q_entry,
    output logic              o_q_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_first_of_packet,
    output logic              o_last_of_packet,
    output logic [15:0]       o_dropped_before,
    output logic              o_reserved_nonzero
);
    import pcd_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_first;
    logic             r_last;
    logic [15:0]      r_drop;
    logic             r_resv;

    logic             load;
    logic             hdr_end;
    logic [7:0]       n_byte;
    logic             n_first;
    logic             n_last;

    always_comb begin
        load    = i_q_valid && (!r_valid || !i_out_stall);
        hdr_end = (r_idx == IDX_W'(HEADER_BYTES - 1));
        o_q_pop = load && (!i_q_entry.is_hdr || hdr_end);
        if (i_q_entry.is_hdr) begin
            n_byte  = i_q_entry.bytes[r_idx];
            n_first = (r_idx == '0);
            n_last  = hdr_end && i_q_entry.last;
        end else begin
            n_byte  = i_q_entry.bytes[HEADER_BYTES-1];
            n_first = 1'b0;
            n_last  = i_q_entry.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= n_byte;
            r_first <= n_first;
            r_last  <= n_last;
            r_drop  <= n_first ? i_q_entry.drop : 16'd0;
            r_resv  <= n_first && i_q_entry.resv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
            if (load && i_q_entry.is_hdr) begin
                r_idx <= hdr_end ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    assign o_out_valid        = r_valid;
    assign o_out_byte         = r_byte;
    assign o_first_of_packet  = r_first;
    assign o_last_of_packet   = r_last;
    assign o_dropped_before   = r_drop;
    assign o_reserved_nonzero = r_resv;

    a_idx_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (i_q_valid && i_q_entry.is_hdr))
        else $error("header index advanced without a header at the queue head");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the control-stream deframer
// Streams well-formed, corrupted and stray control traffic into the unit.
// A bench-side deframer predicts every output word. A monitor compares each
// word field by field as it leaves the block. The sender and the receiver
// are throttled in several patterns.
// ============================================================================
module tb_top;
    import pcd_pkg::*;

    // Cycles to let the block run dry after the last expected word.
    localparam int DRAIN_CYCLES    = 24;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Register index past the end of the map; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_first;
    logic        out_last;
    logic [15:0] out_dropped;
    logic        out_resv;

    always #5 i_clk = ~i_clk;

    pptp_control_deframer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_rx_byte          (rx_byte),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_byte         (out_byte),
        .o_first_of_packet  (out_first),
        .o_last_of_packet   (out_last),
        .o_dropped_before   (out_dropped),
        .o_reserved_nonzero (out_resv)
    );

    // ------------------------------------------------------------------------
    // Bench-side deframer: its own copy of the registers and of the state
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] drops;
        logic        resv;
    } t_frame_word;

    t_frame_word expected_words[$];

    logic [31:0] cfg_magic   = MAGIC_RESET;
    logic [15:0] cfg_maxlen  = MAXLEN_RESET;
    logic [15:0] cfg_ctltype = CTLTYPE_RESET;

    logic [7:0]  hdr_win [HEADER_BYTES];
    int          win_fill   = 0;
    bit          in_body    = 1'b0;
    logic [15:0] body_left  = '0;
    logic [15:0] drop_tally = '0;

    int mismatches      = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int bytes_sent      = 0;

    // Standard message length per control message kind; unknown kinds map to
    // zero so that no header of that kind can pass the size check.
    function automatic logic [15:0] msg_size_for(input logic [15:0] kind);
        case (kind)
            16'd1, 16'd2:                return 16'd156;
            16'd3, 16'd4, 16'd5, 16'd12: return 16'd16;
            16'd6:                       return 16'd20;
            16'd7:                       return 16'd168;
            16'd8:                       return 16'd32;
            16'd9:                       return 16'd220;
            16'd10, 16'd15:              return 16'd24;
            16'd11:                      return 16'd28;
            16'd13:                      return 16'd148;
            16'd14:                      return 16'd40;
            default:                     return 16'd0;
        endcase
    endfunction

    // Advance the bench deframer by one accepted input word and queue the
    // output words it causes.
    function automatic void deframe_byte(input logic [7:0] b);
        t_frame_word w;
        logic [15:0] len;
        logic [15:0] mtype;
        logic [15:0] kind;
        logic [31:0] magic;
        logic        hdr_good;
        if (in_body) begin
            if (body_left != 16'd0) body_left = body_left - 16'd1;
            w = '{b, 1'b0, (body_left == 16'd0), 16'd0, 1'b0};
            expected_words.push_back(w);
            if (body_left == 16'd0) in_body = 1'b0;
            return;
        end
        if (win_fill >= HEADER_BYTES) win_fill = HEADER_BYTES - 1;
        hdr_win[win_fill] = b;
        win_fill++;
        if (win_fill < HEADER_BYTES) return;

        len   = {hdr_win[0], hdr_win[1]};
        mtype = {hdr_win[2], hdr_win[3]};
        magic = {hdr_win[4], hdr_win[5], hdr_win[6], hdr_win[7]};
        kind  = {hdr_win[8], hdr_win[9]};
        hdr_good = (magic == cfg_magic) && (len >= 16'(HEADER_BYTES)) && (len <= cfg_maxlen)
                   && !(mtype == cfg_ctltype && len != msg_size_for(kind));
        if (!hdr_good) begin
            // slide the window by one and count the word that fell out
            for (int k = 0; k < HEADER_BYTES - 1; k++) hdr_win[k] = hdr_win[k + 1];
            win_fill = HEADER_BYTES - 1;
            if (drop_tally != 16'hFFFF) drop_tally = drop_tally + 16'd1;
            return;
        end
        for (int k = 0; k < HEADER_BYTES; k++) begin
            w.data  = hdr_win[k];
            w.first = (k == 0);
            w.last  = (k == HEADER_BYTES - 1) && (len == 16'(HEADER_BYTES));
            w.drops = (k == 0) ? drop_tally : 16'd0;
            w.resv  = (k == 0) && ({hdr_win[10], hdr_win[11]} != 16'd0);
            expected_words.push_back(w);
        end
        drop_tally = '0;
        win_fill   = 0;
        body_left  = len - 16'(HEADER_BYTES);
        in_body    = (body_left != 16'd0);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted output word, then feed each accepted
    // input word to the predictor. Signals read here are the values that
    // the block saw at this same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_output
        t_frame_word want;
        if (i_rst_n) begin
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch($sformatf("word %02h with nothing expected", out_byte));
                end else begin
                    want = expected_words.pop_front();
                    if (out_byte !== want.data)
                        flag_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
                    if (out_first !== want.first)
                        flag_mismatch($sformatf("first %b, want %b", out_first, want.first));
                    if (out_last !== want.last)
                        flag_mismatch($sformatf("last %b, want %b", out_last, want.last));
                    if (out_dropped !== want.drops)
                        flag_mismatch($sformatf("dropped %0d, want %0d",
                                                out_dropped, want.drops));
                    if (out_resv !== want.resv)
                        flag_mismatch($sformatf("reserved %b, want %b", out_resv, want.resv));
                end
            end
            if (in_valid && in_stall === 1'b0) deframe_byte(rx_byte);
        end
    end

    // Receiver: random stall, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one word and hold it until the block takes it. Valid stays high
    // on return so that back-to-back words flow without a bubble.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (in_stall !== 1'b0) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_junk(input int count);
        repeat (count) send_byte(8'($urandom_range(255)));
    endtask

    // Send a 12-byte header, optionally with one bit flipped, then a body.
    task automatic send_frame(input logic [15:0] len, input logic [15:0] mtype,
                              input logic [31:0] magic, input logic [15:0] kind,
                              input logic [15:0] resv, input int body_n,
                              input int flip_bit);
        logic [95:0] hdr;
        hdr = {len, mtype, magic, kind, resv};
        if (flip_bit >= 0) hdr[flip_bit] = ~hdr[flip_bit];
        for (int i = 0; i < HEADER_BYTES; i++) send_byte(hdr[95 - 8 * i -: 8]);
        send_junk(body_n);
    endtask

    // Mostly well-formed messages for the current settings, with stray bytes
    // in front now and then and the odd corrupted header.
    task automatic send_random_message();
        logic [15:0] len;
        logic [15:0] mtype;
        logic [15:0] kind;
        logic [15:0] resv;
        int          span;
        if ($urandom_range(99) < 15) send_junk($urandom_range(6, 1));
        len   = 16'd0;
        mtype = cfg_ctltype;
        kind  = 16'($urandom_range(15, 1));
        // favor short control messages; the long kinds only now and then
        if ($urandom_range(1) == 1 && msg_size_for(kind) <= cfg_maxlen
            && (msg_size_for(kind) <= 16'd40 || $urandom_range(9) == 0))
            len = msg_size_for(kind);
        if (len == 16'd0) begin
            mtype = 16'($urandom_range(65535));
            if (mtype == cfg_ctltype) mtype = ~mtype;
            kind = 16'($urandom_range(65535));
            span = 0;
            if (cfg_maxlen >= 16'd12) span = (cfg_maxlen - 16'd12 > 16'd16) ? 16 : cfg_maxlen - 12;
            len = 16'(12 + $urandom_range(span));
        end
        resv = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1)) : 16'd0;
        send_frame(len, mtype, cfg_magic, kind, resv, len - 12,
                   ($urandom_range(9) == 0) ? int'($urandom_range(95)) : -1);
    endtask

    // Drop valid, wait for every expected word, then let the block run dry.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers while the block is idle; the upper bits of the
    // 16-bit registers carry junk, and a last write to the unused index
    // must leave everything alone.
    task automatic set_config(input logic [31:0] magic, input logic [15:0] maxlen,
                              input logic [15:0] ctl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAGIC_WORD;
        cfg_data  <= magic;
        @(posedge i_clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= {16'($urandom_range(65535)), maxlen};
        @(posedge i_clk);
        cfg_index <= CFG_CONTROL_TYPE;
        cfg_data  <= {16'($urandom_range(65535)), ctl};
        @(posedge i_clk);
        cfg_index <= CFG_UNUSED_INDEX;
        cfg_data  <= $urandom;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        cfg_magic   = magic;
        cfg_maxlen  = maxlen;
        cfg_ctltype = ctl;
    endtask

    task automatic run_phase(input logic [31:0] magic, input logic [15:0] maxlen,
                             input logic [15:0] ctl, input int idle_pct, input int stall_pct);
        int start;
        set_config(magic, maxlen, ctl);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < 12) send_random_message();
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: stray bytes, header-only, reserved flag, a short control
    // message, and the header rejections, ending on a frame that reports them.
    task automatic test_directed_frames();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        // header-only message, reserved field set, two drops reported
        send_frame(16'd12, 16'h0002, MAGIC_RESET, 16'd0, 16'hFFFF, 0, -1);
        // control message at its standard size
        send_frame(16'd16, CTLTYPE_RESET, MAGIC_RESET, 16'd3, 16'h0000, 4, -1);
        // unknown control kind: size taken as zero, header rejected
        send_frame(16'd16, CTLTYPE_RESET, MAGIC_RESET, 16'h0010, 16'h0000, 0, -1);
        // length below the header size
        send_frame(16'd11, 16'h0002, MAGIC_RESET, 16'd0, 16'h0000, 0, -1);
        // length one past the limit
        send_frame(MAXLEN_RESET + 16'd1, 16'h0002, MAGIC_RESET, 16'd0, 16'h0000, 0, -1);
        // clean frame picks up the 36 dropped words above
        send_frame(16'd20, 16'hFFFF, MAGIC_RESET, 16'hFFFF, 16'h0001, 8, -1);
        settle();
    endtask

    // Random traffic under several settings and throttle patterns, the
    // extremes among them; the last one sets the limit below a header.
    task automatic test_random_traffic();
        run_phase(MAGIC_RESET, MAXLEN_RESET, CTLTYPE_RESET, 0, 0);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 64, 0);
        run_phase(32'h0000_0000, 16'd12, 16'hFFFF, 0, 64);
        run_phase($urandom, 16'($urandom_range(400, 40)), 16'($urandom_range(15)), 33, 33);
        run_phase($urandom, 16'd11, CTLTYPE_RESET, 33, 33);
    endtask

    // Hold the receiver off while the sender keeps offering words, so the
    // entry queue fills and the input stalls, then drain. The body alone
    // carries more words than the queue has entries.
    task automatic test_backpressure();
        set_config(MAGIC_RESET, 16'd64, CTLTYPE_RESET);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req = HOLD_OFF_CYCLES;
        send_frame(16'd40, 16'h0002, MAGIC_RESET, 16'd0, 16'h0000, 28, -1);
        settle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_random_traffic();
        test_backpressure();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
